/* rtl/core/positional_list_engine_assert.svh */
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion forms used by the list engine.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ple_pkg.sv */
// ----------------------------------------------------------------------------
// Positional list engine package
// Field widths, command and status codes, and the row control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ple_pkg;

   localparam int DATA_W           = 32;
   localparam int COMMAND_W        = 3;
   localparam int POSITION_W       = 7;
   localparam int STATUS_W         = 3;
   localparam int LENGTH_W         = 7;
   localparam int DEFAULT_CAPACITY = 64;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_APPEND     = 3'd1,
      CMD_INSERT_AT  = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_BACK   = 3'd4,
      CMD_DELETE_AT  = 3'd5,
      CMD_OVERWRITE  = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_BELOW = 3'd2,
      ST_PAST  = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ROW_HOLD   = 2'd0,
      ROW_INSERT = 2'd1,
      ROW_DELETE = 2'd2,
      ROW_WRITE  = 2'd3
   } row_op_type;

   typedef struct packed {
      row_op_type        op;
      logic [DATA_W-1:0] value;
   } row_ctl_type;

   typedef struct packed {
      row_op_type op;
      status_type status;
      logic       removal;
   } decode_type;

endpackage

/* rtl/core/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_stall, req_command, req_position,
// req_value) carries one command per transaction. The response channel
// (rsp_valid, rsp_stall, rsp_removed_value, rsp_status, rsp_length) returns
// exactly one result per command, in order.
// List position p always sits in cell p-1. An insert shifts the cells from
// the target onward one place right, a removal shifts them one place left,
// and every cell moves in the same clock. The result is loaded into the
// response register in the cycle after acceptance, and a new transaction
// is accepted every cycle while the response side keeps up: a throughput
// of one command per clock.
// When the receiver stalls, the response register holds its result and
// req_stall rises until that result is taken.
// Synchronous reset empties the list and the response register; cell
// contents are not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [COMMAND_W-1:0]     req_command,
   input  logic [POSITION_W-1:0]    req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_removed_value,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [LENGTH_W-1:0]      rsp_length
);

`include "positional_list_engine_assert.svh"

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int XW = (CW > LENGTH_W) ? CW : LENGTH_W;

   logic              accept;
   decode_type        dec;
   logic [IW-1:0]     target;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [CW-1:0]     count_next;
   logic [XW-1:0]     count_ext;
   row_ctl_type       row_ctl;
   logic [DATA_W-1:0] cell_value [CAPACITY];
   logic [DATA_W-1:0] cell_tap [CAPACITY];
   logic [DATA_W-1:0] tap_or;
   logic [DATA_W-1:0] removed;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] rsp_removed_value_ff;
   status_type        rsp_status_ff;
   logic [LENGTH_W-1:0] rsp_length_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   ple_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .command    (cmd_type'(req_command)),
      .position   (req_position),
      .count      (count_ff),
      .dec        (dec),
      .target     (target),
      .count_next (count_next)
   );

   assign row_ctl.op    = accept ? dec.op : ROW_HOLD;
   assign row_ctl.value = req_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_value;
      logic [DATA_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = req_value;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end

      ple_cell #(
         .INDEX (i),
         .IDX_W (IW)
      ) u_cell (
         .clock       (clock),
         .ctl         (row_ctl),
         .target      (target),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .tap         (cell_tap[i])
      );
   end

   always_comb begin
      tap_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tap_or = tap_or | cell_tap[i];
      end
   end

   always_comb begin
      if (!dec.removal) begin
         removed = '0;
      end else if (dec.status == ST_OK) begin
         removed = tap_or;
      end else begin
         removed = '1;
      end
   end

   assign count_in     = accept ? count_next : count_ff;
   assign count_ext    = XW'(count_next);
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_removed_value_ff <= removed;
         rsp_status_ff        <= dec.status;
         rsp_length_ff        <= count_ext[LENGTH_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_length        = rsp_length_ff;

   `PLE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY),
                   "Entry count exceeds the capacity.")
   `PLE_ASSERT_NEXT(a_accept_response, clock, reset, accept, rsp_valid_ff,
                    "An accepted transaction produced no response.")
   `PLE_ASSERT_NEXT(a_count_idle, clock, reset, !accept, $stable(count_ff),
                    "Entry count changed without a transaction.")
   `PLE_ASSERT_NEXT(a_full_holds, clock, reset, accept && dec.status == ST_FULL,
                    count_ff == $past(count_ff), "A full list changed its count.")

endmodule

/* rtl/core/ple_cell.sv */
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry and loads, shifts or keeps it under row control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_cell
   import ple_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int IDX_W = 6
) (
   input  logic              clock,
   input  row_ctl_type       ctl,
   input  logic [IDX_W-1:0]  target,
   input  logic [DATA_W-1:0] left_value,
   input  logic [DATA_W-1:0] right_value,
   output logic [DATA_W-1:0] value,
   output logic [DATA_W-1:0] tap
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              at_target;
   logic              past_target;

   assign at_target   = (MY_INDEX == target);
   assign past_target = (MY_INDEX > target);

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         ROW_INSERT: begin
            if (at_target) begin
               value_in = ctl.value;
            end else if (past_target) begin
               value_in = left_value;
            end
         end
         ROW_DELETE: begin
            if (at_target || past_target) begin
               value_in = right_value;
            end
         end
         ROW_WRITE: begin
            if (at_target) begin
               value_in = ctl.value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign tap   = (ctl.op == ROW_DELETE && at_target) ? value_ff : '0;

endmodule

/* rtl/core/ple_ctrl.sv */
// ----------------------------------------------------------------------------
// Positional list engine command decoder
// Checks a command against the entry count and sets up the row operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_ctrl
   import ple_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  cmd_type                          command,
   input  logic [POSITION_W-1:0]            position,
   input  logic [$clog2(CAPACITY+1)-1:0]    count,
   output decode_type                       dec,
   output logic [$clog2(CAPACITY)-1:0]      target,
   output logic [$clog2(CAPACITY+1)-1:0]    count_next
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int XW = (CW > POSITION_W) ? CW : POSITION_W;

   logic [XW-1:0] pos_ext;
   logic [XW-1:0] count_ext;
   logic [XW-1:0] pos_less_one;
   logic          is_full;
   logic          is_empty;
   logic          is_below;
   logic          is_past;

   assign pos_ext      = XW'(position);
   assign count_ext    = XW'(count);
   assign pos_less_one = pos_ext - XW'(1);
   assign is_full      = (count == CW'(CAPACITY));
   assign is_empty     = (count == '0);
   assign is_below     = (position == '0);
   assign is_past      = (pos_ext > count_ext);

   always_comb begin
      dec.op      = ROW_HOLD;
      dec.status  = ST_OK;
      dec.removal = 1'b0;
      target      = '0;
      count_next  = count;
      unique case (command)
         CMD_PUSH_FRONT: begin
            if (is_full) begin
               dec.status = ST_FULL;
            end else begin
               dec.op     = ROW_INSERT;
               count_next = count + CW'(1);
            end
         end
         CMD_APPEND: begin
            if (is_full) begin
               dec.status = ST_FULL;
            end else begin
               dec.op     = ROW_INSERT;
               target     = IW'(count);
               count_next = count + CW'(1);
            end
         end
         CMD_INSERT_AT: begin
            if (is_below) begin
               dec.status = ST_BELOW;
            end else if (is_full) begin
               dec.status = ST_FULL;
            end else if (is_empty) begin
               dec.op     = ROW_INSERT;
               count_next = count + CW'(1);
            end else if (is_past) begin
               dec.status = ST_PAST;
            end else begin
               dec.op     = ROW_INSERT;
               target     = IW'(pos_less_one);
               count_next = count + CW'(1);
            end
         end
         CMD_POP_FRONT: begin
            dec.removal = 1'b1;
            if (is_empty) begin
               dec.status = ST_EMPTY;
            end else begin
               dec.op     = ROW_DELETE;
               count_next = count - CW'(1);
            end
         end
         CMD_POP_BACK: begin
            dec.removal = 1'b1;
            if (is_empty) begin
               dec.status = ST_EMPTY;
            end else begin
               dec.op     = ROW_DELETE;
               target     = IW'(count - CW'(1));
               count_next = count - CW'(1);
            end
         end
         CMD_DELETE_AT: begin
            dec.removal = 1'b1;
            if (is_below) begin
               dec.status = ST_BELOW;
            end else if (is_empty) begin
               dec.status = ST_EMPTY;
            end else if (is_past) begin
               dec.status = ST_PAST;
            end else begin
               dec.op     = ROW_DELETE;
               target     = IW'(pos_less_one);
               count_next = count - CW'(1);
            end
         end
         CMD_OVERWRITE: begin
            if (is_below) begin
               dec.status = ST_BELOW;
            end else if (is_past) begin
               dec.status = ST_PAST;
            end else begin
               dec.op = ROW_WRITE;
               target = IW'(pos_less_one);
            end
         end
         default: begin
            dec.op = ROW_HOLD;
         end
      endcase
   end

endmodule
